>>> rtl/rsoe_pkg.sv
// shared types, codes and helpers for the repeated string-operation engine
// no dependencies; every other file refers to this package by scoped names
package rsoe_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_RDATA = 2'd1;
    localparam logic [1:0] CMD_WACK  = 2'd2;

    localparam logic [1:0] OP_MOVS = 2'd0;
    localparam logic [1:0] OP_CMPS = 2'd1;
    localparam logic [1:0] OP_SCAS = 2'd2;
    localparam logic [1:0] OP_STOS = 2'd3;

    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    localparam logic [1:0] REP_SINGLE = 2'd0;
    localparam logic [1:0] REP_PLAIN  = 2'd1;
    localparam logic [1:0] REP_Z      = 2'd2;
    localparam logic [1:0] REP_NZ     = 2'd3;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_DONE  = 2'd2;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 2;
    localparam int FLAG_AF = 4;
    localparam int FLAG_ZF = 6;
    localparam int FLAG_SF = 7;
    localparam int FLAG_DF = 10;
    localparam int FLAG_OF = 11;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_READ1 = 4'b0010,
        PH_READ2 = 4'b0100,
        PH_WACK  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  operation;
        logic [1:0]  size_code;
        logic [1:0]  repeat_kind;
        logic [31:0] source_pointer;
        logic [31:0] dest_pointer;
        logic [31:0] repeat_count;
        logic [31:0] accumulator;
        logic [31:0] flags_in;
        logic [31:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  request_kind;
        logic [31:0] access_address;
        logic [2:0]  access_size;
        logic [31:0] write_value;
        logic [31:0] source_out;
        logic [31:0] dest_out;
        logic [31:0] count_out;
        logic [31:0] flags_out;
        logic [31:0] iterations_done;
    } t_out_item;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  op_kind;
        logic [1:0]  elem_size;
        logic [1:0]  rep_mode;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] cnt;
        logic [31:0] acc;
        logic [31:0] flags;
        logic [31:0] first;
        logic [31:0] iter;
    } t_state;

    function automatic logic [2:0] elem_bytes(input logic [1:0] size);
        logic [2:0] b;
        case (size)
            SZ_BYTE: b = 3'd1;
            SZ_WORD: b = 3'd2;
            default: b = 3'd4;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] elem_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SZ_BYTE: m = 32'h0000_00FF;
            SZ_WORD: m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/rep_string_op_engine_unit.sv
// the input register holds a transferred item; it is stepped when the output register is
// empty or draining, which loads its result into the output register
// throughput: one item per cycle; the input stalls only while the held item waits on a
// stalled result, and a step that makes no result still consumes its item
// reset (i_rst_n low, synchronous) empties both registers and returns to idle
// with all architectural registers zero
module rep_string_op_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rsoe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rsoe_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    rsoe_pkg::t_in_item  r_in;
    logic                r_out_valid;
    rsoe_pkg::t_out_item r_out;
    rsoe_pkg::t_state    r_state;
    rsoe_pkg::t_state    n_state;
    logic                step_res_valid;
    rsoe_pkg::t_out_item step_res;
    logic                advance;
    logic                in_xfer;

    // the held item steps when the output register is empty or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    rsoe_step u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res_valid) begin
            r_out <= step_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsoe_pkg::t_state'{phase: rsoe_pkg::PH_IDLE, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/rsoe_flags.sv
// compare unit: first minus second at the element width, status flags update
// depends on rsoe_pkg
module rsoe_flags (
    input  logic [1:0]  i_size,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_flags,
    output logic [31:0] o_flags
);

    logic [31:0] mask;
    logic [31:0] a_m;
    logic [31:0] b_m;
    logic [32:0] diff;
    logic [31:0] r;
    logic [31:0] ovf_vec;
    logic        sign_bit;
    logic        ovf_bit;

    always_comb begin
        mask    = rsoe_pkg::elem_mask(i_size);
        a_m     = i_a & mask;
        b_m     = i_b & mask;
        diff    = {1'b0, a_m} - {1'b0, b_m};
        r       = diff[31:0] & mask;
        ovf_vec = (a_m ^ b_m) & (a_m ^ r);
        case (i_size)
            rsoe_pkg::SZ_BYTE: begin
                sign_bit = r[7];
                ovf_bit  = ovf_vec[7];
            end
            rsoe_pkg::SZ_WORD: begin
                sign_bit = r[15];
                ovf_bit  = ovf_vec[15];
            end
            default: begin
                sign_bit = r[31];
                ovf_bit  = ovf_vec[31];
            end
        endcase

        o_flags = i_flags;
        // borrow out of the masked subtract is the unsigned less-than
        o_flags[rsoe_pkg::FLAG_CF] = diff[32];
        o_flags[rsoe_pkg::FLAG_PF] = ~(^r[7:0]);
        o_flags[rsoe_pkg::FLAG_AF] = a_m[4] ^ b_m[4] ^ r[4];
        o_flags[rsoe_pkg::FLAG_ZF] = (r == 32'd0);
        o_flags[rsoe_pkg::FLAG_SF] = sign_bit;
        o_flags[rsoe_pkg::FLAG_OF] = ovf_bit;
    end

endmodule

>>> rtl/rsoe_step.sv
// one sequencer step: next architectural state and the memory request it causes
// depends on rsoe_pkg and rsoe_flags
module rsoe_step (
    input  rsoe_pkg::t_state    i_state,
    input  rsoe_pkg::t_in_item  i_item,
    output rsoe_pkg::t_state    o_state,
    output logic                o_res_valid,
    output rsoe_pkg::t_out_item o_res
);

    rsoe_pkg::t_state    n_st;
    rsoe_pkg::t_out_item res;
    logic [31:0]         cmp_flags;
    logic [31:0]         cmp_a;
    logic [31:0]         bytes32;
    logic [31:0]         delta;
    logic                do_end;
    logic                do_issue;
    logic                do_finish;
    logic                is_cmp;
    logic                stop;

    // cmps second read compares against the saved source element
    assign cmp_a = (i_state.phase == rsoe_pkg::PH_READ2) ? i_state.first : i_state.acc;

    rsoe_flags u_flags (
        .i_size  (i_state.elem_size),
        .i_a     (cmp_a),
        .i_b     (i_item.read_data),
        .i_flags (i_state.flags),
        .o_flags (cmp_flags)
    );

    always_comb begin
        bytes32 = {29'd0, rsoe_pkg::elem_bytes(i_state.elem_size)};
        delta   = i_state.flags[rsoe_pkg::FLAG_DF] ? (32'd0 - bytes32) : bytes32;

        n_st        = i_state;
        res         = '0;
        o_res_valid = 1'b0;
        do_end      = 1'b0;
        do_issue    = 1'b0;
        do_finish   = 1'b0;
        is_cmp      = 1'b0;
        stop        = 1'b0;

        unique case (i_item.command)
            rsoe_pkg::CMD_START: begin
                n_st.op_kind   = i_item.operation;
                n_st.elem_size = (i_item.size_code == 2'd3) ? rsoe_pkg::SZ_DWORD
                                                            : i_item.size_code;
                n_st.rep_mode  = i_item.repeat_kind;
                n_st.src       = i_item.source_pointer;
                n_st.dst       = i_item.dest_pointer;
                n_st.cnt       = i_item.repeat_count;
                n_st.acc       = i_item.accumulator;
                n_st.flags     = i_item.flags_in;
                n_st.iter      = 32'd0;
                if (i_item.repeat_kind != rsoe_pkg::REP_SINGLE &&
                    i_item.repeat_count == 32'd0) begin
                    do_finish = 1'b1;
                end else begin
                    do_issue = 1'b1;
                end
            end
            rsoe_pkg::CMD_RDATA: begin
                if (i_state.phase == rsoe_pkg::PH_READ1) begin
                    unique case (i_state.op_kind)
                        rsoe_pkg::OP_MOVS: begin
                            n_st.phase         = rsoe_pkg::PH_WACK;
                            o_res_valid        = 1'b1;
                            res.request_kind   = rsoe_pkg::REQ_WRITE;
                            res.access_address = i_state.dst;
                            res.write_value    = i_item.read_data
                                               & rsoe_pkg::elem_mask(i_state.elem_size);
                        end
                        rsoe_pkg::OP_CMPS: begin
                            n_st.first         = i_item.read_data
                                               & rsoe_pkg::elem_mask(i_state.elem_size);
                            n_st.phase         = rsoe_pkg::PH_READ2;
                            o_res_valid        = 1'b1;
                            res.request_kind   = rsoe_pkg::REQ_READ;
                            res.access_address = i_state.dst;
                        end
                        rsoe_pkg::OP_SCAS: begin
                            n_st.flags = cmp_flags;
                            n_st.dst   = i_state.dst + delta;
                            do_end     = 1'b1;
                        end
                        default: ;
                    endcase
                end else if (i_state.phase == rsoe_pkg::PH_READ2) begin
                    n_st.flags = cmp_flags;
                    n_st.src   = i_state.src + delta;
                    n_st.dst   = i_state.dst + delta;
                    do_end     = 1'b1;
                end
            end
            rsoe_pkg::CMD_WACK: begin
                if (i_state.phase == rsoe_pkg::PH_WACK) begin
                    if (i_state.op_kind == rsoe_pkg::OP_MOVS) begin
                        n_st.src = i_state.src + delta;
                    end
                    n_st.dst = i_state.dst + delta;
                    do_end   = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_end) begin
            if (n_st.rep_mode == rsoe_pkg::REP_SINGLE) begin
                do_finish = 1'b1;
            end else begin
                n_st.cnt  = n_st.cnt - 32'd1;
                n_st.iter = n_st.iter + 32'd1;
                is_cmp    = (n_st.op_kind == rsoe_pkg::OP_CMPS) ||
                            (n_st.op_kind == rsoe_pkg::OP_SCAS);
                // zero flag only ends the loop for the compare operations
                stop = (n_st.cnt == 32'd0)
                    || (is_cmp && n_st.rep_mode == rsoe_pkg::REP_Z
                        && !n_st.flags[rsoe_pkg::FLAG_ZF])
                    || (is_cmp && n_st.rep_mode == rsoe_pkg::REP_NZ
                        && n_st.flags[rsoe_pkg::FLAG_ZF]);
                if (stop) begin
                    do_finish = 1'b1;
                end else begin
                    do_issue = 1'b1;
                end
            end
        end

        if (do_issue) begin
            o_res_valid = 1'b1;
            unique case (n_st.op_kind) inside
                rsoe_pkg::OP_MOVS, rsoe_pkg::OP_CMPS: begin
                    n_st.phase         = rsoe_pkg::PH_READ1;
                    res.request_kind   = rsoe_pkg::REQ_READ;
                    res.access_address = n_st.src;
                end
                rsoe_pkg::OP_SCAS: begin
                    n_st.phase         = rsoe_pkg::PH_READ1;
                    res.request_kind   = rsoe_pkg::REQ_READ;
                    res.access_address = n_st.dst;
                end
                default: begin
                    n_st.phase         = rsoe_pkg::PH_WACK;
                    res.request_kind   = rsoe_pkg::REQ_WRITE;
                    res.access_address = n_st.dst;
                    res.write_value    = n_st.acc & rsoe_pkg::elem_mask(n_st.elem_size);
                end
            endcase
        end

        if (do_finish) begin
            o_res_valid        = 1'b1;
            n_st.phase         = rsoe_pkg::PH_IDLE;
            res.request_kind   = rsoe_pkg::REQ_DONE;
            res.access_address = 32'd0;
            res.write_value    = 32'd0;
        end

        res.access_size     = rsoe_pkg::elem_bytes(n_st.elem_size);
        res.source_out      = n_st.src;
        res.dest_out        = n_st.dst;
        res.count_out       = n_st.cnt;
        res.flags_out       = n_st.flags;
        res.iterations_done = n_st.iter;

        o_state = n_st;
        o_res   = res;
    end

endmodule

>>> rtl/rsoe_checker.sv
// port-level checks for rep_string_op_engine_unit, attached by bind
// depends on rsoe_pkg and the top level
module rsoe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input rsoe_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rsoe_pkg::t_out_item o_out_item
);

    // a stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("result or stall present after reset");

    a_size_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.access_size == 3'd1 ||
                         o_out_item.access_size == 3'd2 ||
                         o_out_item.access_size == 3'd4))
        else $error("illegal access size");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.request_kind == rsoe_pkg::REQ_DONE)
            |-> (o_out_item.access_address == 32'd0 && o_out_item.write_value == 32'd0))
        else $error("done result carries address or data");

    // a start transfer is always answered: stage one never blocks an idle output
    a_start_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_item.command == rsoe_pkg::CMD_START
            && !o_out_valid) |=> ##1 o_out_valid)
        else $error("start transfer produced no result");

endmodule

bind rep_string_op_engine_unit rsoe_checker u_rsoe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

>>> bench/tb.sv
// self-checking bench for rep_string_op_engine_unit: directed rows, then random string ops
// depends on rsoe_pkg for the transfer structs and codes; drives the block at the clock edge
module tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TOTAL = 600;
    localparam int STALL_PCT = 31;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        rsoe_pkg::t_in_item  stim;
        bit                  pinned;
        rsoe_pkg::t_out_item want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    rsoe_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    rsoe_pkg::t_out_item o_out_item;

    rep_string_op_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the sequencer state
    rsoe_pkg::t_phase eng_phase;
    logic [1:0]       eng_op, eng_sz, eng_rep;
    logic [31:0]      eng_src, eng_dst, eng_cnt, eng_acc, eng_flags, eng_first, eng_iter;

    rsoe_pkg::t_out_item pending_results[$];
    int                  items_sent = 0;
    int                  fails = 0;
    int                  quiet_cycles = 0;
    bit                  calm = 1'b0;

    function automatic logic [31:0] lane_mask(input logic [1:0] sz);
        if (sz == rsoe_pkg::SZ_BYTE) return 32'h0000_00FF;
        if (sz == rsoe_pkg::SZ_WORD) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [2:0] lane_bytes();
        return 3'd1 << eng_sz;
    endfunction

    function automatic logic [31:0] stride();
        logic [31:0] b;
        b = 32'(lane_bytes());
        return eng_flags[rsoe_pkg::FLAG_DF] ? 32'd0 - b : b;
    endfunction

    // flags of a - b at the element width, other bits kept
    function automatic logic [31:0] subtract_flags(input logic [31:0] a_in,
                                                   input logic [31:0] b_in);
        logic [31:0] m, top, a, b, r, f;
        m = lane_mask(eng_sz);
        top = (m >> 1) + 32'd1;
        a = a_in & m;
        b = b_in & m;
        r = (a - b) & m;
        f = eng_flags;
        f[rsoe_pkg::FLAG_CF] = a < b;
        f[rsoe_pkg::FLAG_PF] = ~^r[7:0];
        f[rsoe_pkg::FLAG_AF] = a[4] ^ b[4] ^ r[4];
        f[rsoe_pkg::FLAG_ZF] = r == 32'd0;
        f[rsoe_pkg::FLAG_SF] = |(r & top);
        f[rsoe_pkg::FLAG_OF] = |((a ^ b) & (a ^ r) & top);
        return f;
    endfunction

    function automatic rsoe_pkg::t_out_item snapshot(input logic [1:0] kind,
                                                     input logic [31:0] addr,
                                                     input logic [31:0] val);
        rsoe_pkg::t_out_item o;
        o.request_kind = kind;
        o.access_address = addr;
        o.access_size = lane_bytes();
        o.write_value = val;
        o.source_out = eng_src;
        o.dest_out = eng_dst;
        o.count_out = eng_cnt;
        o.flags_out = eng_flags;
        o.iterations_done = eng_iter;
        return o;
    endfunction

    function automatic rsoe_pkg::t_out_item close_instr();
        eng_phase = rsoe_pkg::PH_IDLE;
        return snapshot(rsoe_pkg::REQ_DONE, 32'd0, 32'd0);
    endfunction

    function automatic rsoe_pkg::t_out_item issue_access();
        if (eng_op == rsoe_pkg::OP_MOVS || eng_op == rsoe_pkg::OP_CMPS) begin
            eng_phase = rsoe_pkg::PH_READ1;
            return snapshot(rsoe_pkg::REQ_READ, eng_src, 32'd0);
        end else if (eng_op == rsoe_pkg::OP_SCAS) begin
            eng_phase = rsoe_pkg::PH_READ1;
            return snapshot(rsoe_pkg::REQ_READ, eng_dst, 32'd0);
        end
        eng_phase = rsoe_pkg::PH_WACK;
        return snapshot(rsoe_pkg::REQ_WRITE, eng_dst, eng_acc & lane_mask(eng_sz));
    endfunction

    function automatic rsoe_pkg::t_out_item next_iteration();
        bit stop;
        if (eng_rep == rsoe_pkg::REP_SINGLE) return close_instr();
        eng_cnt = eng_cnt - 32'd1;
        eng_iter = eng_iter + 32'd1;
        stop = eng_cnt == 32'd0;
        // zero flag only ends compare-type loops
        if (eng_op == rsoe_pkg::OP_CMPS || eng_op == rsoe_pkg::OP_SCAS) begin
            if (eng_rep == rsoe_pkg::REP_Z && !eng_flags[rsoe_pkg::FLAG_ZF]) stop = 1'b1;
            if (eng_rep == rsoe_pkg::REP_NZ && eng_flags[rsoe_pkg::FLAG_ZF]) stop = 1'b1;
        end
        return stop ? close_instr() : issue_access();
    endfunction

    task automatic clear_engine();
        eng_phase = rsoe_pkg::PH_IDLE;
        {eng_op, eng_sz, eng_rep} = '0;
        {eng_src, eng_dst, eng_cnt, eng_acc, eng_flags, eng_first, eng_iter} = '0;
    endtask

    task automatic advance_engine(input rsoe_pkg::t_in_item it, output bit produced,
                                  output rsoe_pkg::t_out_item res);
        logic [31:0] rd;
        rd = it.read_data;
        produced = 1'b1;
        res = '0;
        if (it.command == rsoe_pkg::CMD_START) begin
            eng_op = it.operation;
            eng_sz = it.size_code == 2'd3 ? rsoe_pkg::SZ_DWORD : it.size_code;
            eng_rep = it.repeat_kind;
            eng_src = it.source_pointer;
            eng_dst = it.dest_pointer;
            eng_cnt = it.repeat_count;
            eng_acc = it.accumulator;
            eng_flags = it.flags_in;
            eng_iter = 32'd0;
            res = (eng_rep != rsoe_pkg::REP_SINGLE && eng_cnt == 32'd0) ? close_instr()
                                                                          : issue_access();
        end else if (it.command == rsoe_pkg::CMD_RDATA && eng_phase == rsoe_pkg::PH_READ1) begin
            case (eng_op)
                rsoe_pkg::OP_MOVS: begin
                    eng_phase = rsoe_pkg::PH_WACK;
                    res = snapshot(rsoe_pkg::REQ_WRITE, eng_dst, rd & lane_mask(eng_sz));
                end
                rsoe_pkg::OP_CMPS: begin
                    eng_first = rd & lane_mask(eng_sz);
                    eng_phase = rsoe_pkg::PH_READ2;
                    res = snapshot(rsoe_pkg::REQ_READ, eng_dst, 32'd0);
                end
                rsoe_pkg::OP_SCAS: begin
                    eng_flags = subtract_flags(eng_acc, rd);
                    eng_dst = eng_dst + stride();
                    res = next_iteration();
                end
                default: produced = 1'b0;
            endcase
        end else if (it.command == rsoe_pkg::CMD_RDATA && eng_phase == rsoe_pkg::PH_READ2) begin
            eng_flags = subtract_flags(eng_first, rd);
            eng_src = eng_src + stride();
            eng_dst = eng_dst + stride();
            res = next_iteration();
        end else if (it.command == rsoe_pkg::CMD_WACK && eng_phase == rsoe_pkg::PH_WACK) begin
            if (eng_op == rsoe_pkg::OP_MOVS) eng_src = eng_src + stride();
            eng_dst = eng_dst + stride();
            res = next_iteration();
        end else begin
            produced = 1'b0;
        end
    endtask

    // one input transfer; the expectation is taken at the edge of acceptance
    task automatic send_item(input rsoe_pkg::t_in_item it, input bit pinned,
                             input rsoe_pkg::t_out_item pinned_val);
        bit                  produced;
        rsoe_pkg::t_out_item res;
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        advance_engine(it, produced, res);
        if (produced) begin
            pending_results.push_back(pinned ? pinned_val : res);
        end
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic rsoe_pkg::t_in_item mk(input logic [1:0] cmd, input logic [1:0] op,
                                              input logic [1:0] sz, input logic [1:0] rk,
                                              input logic [31:0] src, input logic [31:0] dst,
                                              input logic [31:0] cnt, input logic [31:0] acc,
                                              input logic [31:0] flg, input logic [31:0] rd);
        return '{cmd, op, sz, rk, src, dst, cnt, acc, flg, rd};
    endfunction

    function automatic rsoe_pkg::t_in_item rand_fields();
        rsoe_pkg::t_in_item it;
        it.command = 2'($urandom_range(3));
        it.operation = 2'($urandom_range(3));
        it.size_code = 2'($urandom_range(3));
        it.repeat_kind = 2'($urandom_range(3));
        it.source_pointer = $urandom;
        it.dest_pointer = $urandom;
        it.repeat_count = $urandom;
        it.accumulator = $urandom;
        it.flags_in = $urandom;
        it.read_data = $urandom;
        return it;
    endfunction

    function automatic rsoe_pkg::t_in_item rand_start();
        rsoe_pkg::t_in_item it;
        int                 pick;
        it = rand_fields();
        it.command = rsoe_pkg::CMD_START;
        // pointers near the top of the address space to exercise wrap
        if ($urandom_range(3) == 0) it.source_pointer = 32'hFFFF_FFF0 + $urandom_range(15);
        if ($urandom_range(3) == 0) it.dest_pointer = 32'hFFFF_FFF0 + $urandom_range(15);
        pick = $urandom_range(99);
        if (pick < 70) it.repeat_count = $urandom_range(6);
        else if (pick < 80) it.repeat_count = 32'hFFFF_FFFF;
        return it;
    endfunction

    // the command the sequencer waits for, with data that often matches
    function automatic rsoe_pkg::t_in_item rand_reply();
        rsoe_pkg::t_in_item it;
        logic [31:0]        m;
        it = rand_fields();
        m = lane_mask(eng_sz);
        it.command = eng_phase == rsoe_pkg::PH_WACK ? rsoe_pkg::CMD_WACK : rsoe_pkg::CMD_RDATA;
        if (eng_phase == rsoe_pkg::PH_READ1 && eng_op == rsoe_pkg::OP_SCAS
            && $urandom_range(99) < 40)
            it.read_data = (it.read_data & ~m) | (eng_acc & m);
        if (eng_phase == rsoe_pkg::PH_READ2 && $urandom_range(99) < 40)
            it.read_data = (it.read_data & ~m) | eng_first;
        return it;
    endfunction

    task automatic check_field(input string tag, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= 10)
                $display("mismatch %s: expected %h, got %h", tag, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        rsoe_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result transfer: %h", o_out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("request_kind", 32'(want.request_kind),
                            32'(o_out_item.request_kind));
                check_field("access_address", want.access_address, o_out_item.access_address);
                check_field("access_size", 32'(want.access_size), 32'(o_out_item.access_size));
                check_field("write_value", want.write_value, o_out_item.write_value);
                check_field("source_out", want.source_out, o_out_item.source_out);
                check_field("dest_out", want.dest_out, o_out_item.dest_out);
                check_field("count_out", want.count_out, o_out_item.count_out);
                check_field("flags_out", want.flags_out, o_out_item.flags_out);
                check_field("iterations_done", want.iterations_done,
                            o_out_item.iterations_done);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        t_row                rows[$];
        rsoe_pkg::t_out_item none;
        int                  steps;
        bit                  paused;
        none = '0;
        paused = 1'b0;
        clear_engine();

        // ignored while idle: read data, write ack, unused command
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, rsoe_pkg::OP_MOVS, rsoe_pkg::SZ_BYTE,
                            rsoe_pkg::REP_SINGLE, '0, '0, '0, '0, '0, 32'hFFFF_FFFF),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_WACK, rsoe_pkg::OP_STOS, 2'd3, rsoe_pkg::REP_NZ,
                            '1, '1, '1, '1, '1, '1), 1'b0, none});
        rows.push_back('{mk(CMD_UNUSED, rsoe_pkg::OP_CMPS, rsoe_pkg::SZ_WORD, rsoe_pkg::REP_Z,
                            '1, '0, '1, '0, '1, '0), 1'b0, none});
        // rep with zero count finishes at once
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_MOVS, rsoe_pkg::SZ_DWORD,
                            rsoe_pkg::REP_PLAIN, 32'h1000, 32'h2000, '0, 32'h55, '0, '0),
                         1'b1,
                         '{rsoe_pkg::REQ_DONE, 32'h0, 3'd4, 32'h0, 32'h1000, 32'h2000, 32'h0,
                           32'h0, 32'h0}});
        // single stos, byte lane of an all-ones accumulator
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_STOS, rsoe_pkg::SZ_BYTE,
                            rsoe_pkg::REP_SINGLE, '0, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF,
                            32'hFFFF_FBFF, '0), 1'b1,
                         '{rsoe_pkg::REQ_WRITE, 32'hFFFF_FFFF, 3'd1, 32'hFF, 32'h0,
                           32'hFFFF_FFFF, 32'h0, 32'hFFFF_FBFF, 32'h0}});
        rows.push_back('{mk(rsoe_pkg::CMD_WACK, rsoe_pkg::OP_MOVS, rsoe_pkg::SZ_BYTE,
                            rsoe_pkg::REP_SINGLE, '0, '0, '0, '0, '0, '0), 1'b0, none});
        // rep movs going down across address zero
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_MOVS, rsoe_pkg::SZ_DWORD,
                            rsoe_pkg::REP_PLAIN, '0, 32'h4, 32'h2, '0, 32'h400, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0,
                            32'hFFFF_FFFF), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_WACK, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_WACK, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                         1'b0, none});
        // repz cmps: one equal pair, then a signed overflow pair ends it
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_CMPS, rsoe_pkg::SZ_WORD,
                            rsoe_pkg::REP_Z, 32'h100, 32'h200, 32'h3, '0, '0, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0,
                            32'hABCD_1234), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0,
                            32'h0000_1234), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0,
                            32'h0000_8000), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0,
                            32'h0000_0001), 1'b0, none});
        // repnz scas, all-ones count, stops on a match
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_SCAS, rsoe_pkg::SZ_BYTE,
                            rsoe_pkg::REP_NZ, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h80,
                            '0, '0), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0, 32'h7F),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0, 32'hFF80),
                         1'b0, none});
        // size code three acts as doubleword
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_SCAS, 2'd3, rsoe_pkg::REP_PLAIN,
                            '0, 32'h40, 32'h1, '0, '0, '0), 1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0, 32'h1),
                         1'b0, none});
        // start while busy abandons the cmps, then a stray read is ignored
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_CMPS, rsoe_pkg::SZ_BYTE,
                            rsoe_pkg::REP_SINGLE, 32'h10, 32'h20, '0, '0, '0, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_START, rsoe_pkg::OP_STOS, rsoe_pkg::SZ_WORD,
                            rsoe_pkg::REP_Z, '0, 32'h30, 32'h1, 32'h1234_5678, 32'h400, '0),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_RDATA, '0, '0, '0, '0, '0, '0, '0, '0, 32'h5),
                         1'b0, none});
        rows.push_back('{mk(rsoe_pkg::CMD_WACK, '0, '0, '0, '0, '0, '0, '0, '0, '0),
                         1'b0, none});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) send_item(rows[k].stim, rows[k].pinned, rows[k].want);
        hold_until_drained();

        while (items_sent < ITEM_TOTAL) begin
            calm = items_sent > 250 && items_sent < 380;
            send_item(rand_start(), 1'b0, none);
            steps = $urandom_range(1, 14);
            while (eng_phase != rsoe_pkg::PH_IDLE && steps > 0) begin
                if ($urandom_range(99) < 8) send_item(rand_fields(), 1'b0, none);
                else send_item(rand_reply(), 1'b0, none);
                steps--;
            end
            if (!paused && items_sent > ITEM_TOTAL / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rsoe_pkg.sv
rtl/rsoe_flags.sv
rtl/rsoe_step.sv
rtl/rep_string_op_engine_unit.sv
rtl/rsoe_checker.sv
bench/tb.sv
